// ===== rtl/uhd_pkg.sv =====
`timescale 1ns / 1ps
package uhd_pkg;

   localparam int unsigned MaxOut = 3;
   localparam int unsigned CountW = 2;

   localparam logic [7:0] CharUnderscore = 8'h5F;
   localparam logic [7:0] CharZero       = 8'h30;
   localparam logic [7:0] CharNine       = 8'h39;
   localparam logic [7:0] CharUpperA     = 8'h41;
   localparam logic [7:0] CharUpperF     = 8'h46;
   localparam logic [3:0] LetterOffset   = 4'd9;

   localparam logic [CountW-1:0] PendNone  = 2'd0;
   localparam logic [CountW-1:0] PendUnder = 2'd1;
   localparam logic [CountW-1:0] PendDigit = 2'd2;

   typedef logic [7:0] byte_type;

   typedef struct packed {
      logic [CountW-1:0] count;
      byte_type          digit;
   } pend_type;

   typedef struct packed {
      logic [CountW-1:0]            count;
      logic [MaxOut-1:0][7:0]       bytes;
      logic [MaxOut-1:0]            lasts;
   } burst_type;

   typedef struct packed {
      logic [CountW-1:0] count;
      logic              load_ok;
   } burst_status_type;

   function automatic logic is_dec_char(input byte_type c);
      return (c >= CharZero) && (c <= CharNine);
   endfunction

   function automatic logic is_hex(input byte_type c);
      return is_dec_char(c) || ((c >= CharUpperA) && (c <= CharUpperF));
   endfunction

   function automatic logic [3:0] hex_val(input byte_type c);
      return is_dec_char(c) ? c[3:0] : c[3:0] + LetterOffset;
   endfunction

endpackage

// ===== rtl/underscore_hex_escape_decoder.sv =====
`timescale 1ns / 1ps
// channel  ports                          direction  fields
// req      req_valid req_stall            in         req_byte[7:0] req_last
// rsp      rsp_valid rsp_stall            out        rsp_byte[7:0] rsp_last
//
// One input byte per cycle while req_stall is low; input register, then result buffer.
// A broken escape yields a burst of up to three bytes, drained from the result
// buffer one per cycle while rsp_stall is low; the input register waits as it drains.
// Synchronous active-high reset clears valids and the held escape state.
// req_stall rises only when the input register holds a byte the buffer cannot take.
module underscore_hex_escape_decoder (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  uhd_pkg::byte_type req_byte,
   input  logic              req_last,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output uhd_pkg::byte_type rsp_byte,
   output logic              rsp_last
);
   import uhd_pkg::*;

   logic             in_vld_ff, in_vld_in;
   byte_type         in_byte_ff;
   logic             in_last_ff;
   pend_type         pend_ff, pend_in, pend_next;
   burst_type        burst;
   burst_status_type status;
   logic             advance;
   logic             req_xfer;

   assign advance   = in_vld_ff && status.load_ok;
   assign req_stall = in_vld_ff && !status.load_ok;
   assign req_xfer  = req_valid && !req_stall;
   assign in_vld_in = req_xfer || (in_vld_ff && !advance);
   assign pend_in   = advance ? pend_next : pend_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
         pend_ff   <= '0;
      end else begin
         in_vld_ff <= in_vld_in;
         pend_ff   <= pend_in;
      end
      if (req_xfer) begin
         in_byte_ff <= req_byte;
         in_last_ff <= req_last;
      end
   end

   uhd_step u_step (
      .in_byte   (in_byte_ff),
      .in_last   (in_last_ff),
      .pend      (pend_ff),
      .pend_next (pend_next),
      .burst     (burst)
   );

   uhd_burst u_burst (
      .clock     (clock),
      .reset     (reset),
      .load      (advance),
      .burst     (burst),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_byte  (rsp_byte),
      .rsp_last  (rsp_last)
   );

   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_vld_ff)
      else $error("stall without a held item");

   a_last_ends_burst: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |-> (status.count == 2'd1))
      else $error("last byte not at end of burst");

   a_last_clears_pend: assert property (@(posedge clock) disable iff (reset)
      (advance && in_last_ff) |=> (pend_ff.count == PendNone))
      else $error("pending escape survives end of string");

   a_pend_code: assert property (@(posedge clock) disable iff (reset)
      pend_ff.count != 2'd3)
      else $error("unused pending code reached");

endmodule

// ===== rtl/uhd_step.sv =====
`timescale 1ns / 1ps
module uhd_step (
   input  uhd_pkg::byte_type  in_byte,
   input  logic               in_last,
   input  uhd_pkg::pend_type  pend,
   output uhd_pkg::pend_type  pend_next,
   output uhd_pkg::burst_type burst
);
   import uhd_pkg::*;

   logic [CountW-1:0] pc;
   logic [CountW-1:0] n;
   logic              hex;
   pend_type          np;

   always_comb begin
      pc    = (pend.count == 2'd3) ? PendDigit : pend.count;
      hex   = is_hex(in_byte);
      n     = '0;
      np    = pend;
      burst = '0;
      np.count = pc;

      if (pc == PendDigit && hex) begin
         burst.bytes[n] = {hex_val(pend.digit), hex_val(in_byte)};
         n  = n + 2'd1;
         np = '0;
      end else if (pc == PendUnder && hex) begin
         np.digit = in_byte;
         np.count = PendDigit;
      end else begin
         if (pc != PendNone) begin
            burst.bytes[n] = CharUnderscore;
            n = n + 2'd1;
         end
         if (pc == PendDigit) begin
            burst.bytes[n] = pend.digit;
            n = n + 2'd1;
         end
         np = '0;
         if (in_byte == CharUnderscore) begin
            np.count = PendUnder;
         end else begin
            burst.bytes[n] = in_byte;
            n = n + 2'd1;
         end
      end

      if (in_last) begin
         if (np.count != PendNone) begin
            burst.bytes[n] = CharUnderscore;
            n = n + 2'd1;
         end
         if (np.count == PendDigit) begin
            burst.bytes[n] = np.digit;
            n = n + 2'd1;
         end
         np = '0;
         if (n != '0) begin
            burst.lasts[n - 2'd1] = 1'b1;
         end
      end

      burst.count = n;
      pend_next   = np;
   end

endmodule

// ===== rtl/uhd_burst.sv =====
`timescale 1ns / 1ps
module uhd_burst (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      load,
   input  uhd_pkg::burst_type        burst,
   output uhd_pkg::burst_status_type status,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output uhd_pkg::byte_type         rsp_byte,
   output logic                      rsp_last
);
   import uhd_pkg::*;

   logic [CountW-1:0]      count_ff, count_in;
   logic [MaxOut-1:0][7:0] bytes_ff, bytes_in;
   logic [MaxOut-1:0]      lasts_ff, lasts_in;
   logic                   pop;

   assign rsp_valid      = (count_ff != '0);
   assign rsp_byte       = bytes_ff[0];
   assign rsp_last       = lasts_ff[0];
   assign pop            = rsp_valid && !rsp_stall;
   assign status.count   = count_ff;
   assign status.load_ok = (count_ff == '0) || (count_ff == 2'd1 && pop);

   always_comb begin
      count_in = count_ff;
      bytes_in = bytes_ff;
      lasts_in = lasts_ff;
      priority if (load) begin
         count_in = burst.count;
         bytes_in = burst.bytes;
         lasts_in = burst.lasts;
      end else if (pop) begin
         count_in = count_ff - 2'd1;
         bytes_in = {8'h00, bytes_ff[MaxOut-1:1]};
         lasts_in = {1'b0, lasts_ff[MaxOut-1:1]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      bytes_ff <= bytes_in;
      lasts_ff <= lasts_in;
   end

endmodule

// ===== sim/uhd_decode_check.sv =====
`timescale 1ns / 1ps
module uhd_decode_check (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  uhd_pkg::byte_type req_byte,
   input  logic              req_last,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  uhd_pkg::byte_type rsp_byte,
   input  logic              rsp_last,
   output int                errors,
   output int                outstanding
);
   import uhd_pkg::*;

   typedef struct packed {
      byte_type value;
      logic     last;
   } decoded_type;

   decoded_type       decoded_q[$];
   byte_type          burst_q[$];
   logic [CountW-1:0] held_count;
   byte_type          held_digit;

   function automatic logic is_upper_hex(input byte_type c);
      return ((c >= CharZero) && (c <= CharNine)) || ((c >= CharUpperA) && (c <= CharUpperF));
   endfunction

   function automatic logic [3:0] nibble(input byte_type c);
      byte_type v;
      if (c <= CharNine) begin
         v = c - CharZero;
      end else begin
         v = c - CharUpperA + 8'd10;
      end
      return v[3:0];
   endfunction

   task automatic flush_held();
      if (held_count >= PendUnder) burst_q.push_back(CharUnderscore);
      if (held_count >= PendDigit) burst_q.push_back(held_digit);
      held_count = PendNone;
      held_digit = '0;
   endtask

   task automatic decode_byte(input byte_type c, input logic eos);
      decoded_type d;
      burst_q.delete();
      if (held_count > PendDigit) held_count = PendDigit;
      if (held_count == PendDigit && is_upper_hex(c)) begin
         burst_q.push_back({nibble(held_digit), nibble(c)});
         held_count = PendNone;
         held_digit = '0;
      end else if (held_count == PendUnder && is_upper_hex(c)) begin
         held_digit = c;
         held_count = PendDigit;
      end else begin
         flush_held();
         if (c == CharUnderscore) begin
            held_count = PendUnder;
         end else begin
            burst_q.push_back(c);
         end
      end
      if (eos) flush_held();
      for (int i = 0; i < burst_q.size(); i++) begin
         d.value = burst_q[i];
         d.last  = eos && (i == burst_q.size() - 1);
         decoded_q.push_back(d);
      end
   endtask

   always @(posedge clock) begin
      decoded_type got;
      decoded_type want;
      if (reset) begin
         held_count = PendNone;
         held_digit = '0;
         decoded_q.delete();
         errors = 0;
      end else begin
         if (req_valid && !req_stall) decode_byte(req_byte, req_last);
         if (rsp_valid && !rsp_stall) begin
            got.value = rsp_byte;
            got.last  = rsp_last;
            if (decoded_q.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("%0t: unexpected transfer: byte %h last %b", $time, got.value,
                           got.last);
            end else begin
               want = decoded_q.pop_front();
               if (want.value !== got.value || want.last !== got.last) begin
                  errors++;
                  if (errors <= 10)
                     $display("%0t: mismatch: expected byte %h last %b, got byte %h last %b",
                              $time, want.value, want.last, got.value, got.last);
               end
            end
         end
      end
      outstanding = decoded_q.size();
   end

endmodule

// ===== sim/tb_underscore_hex_escape_decoder.sv =====
`timescale 1ns / 1ps
module tb_underscore_hex_escape_decoder;
   import uhd_pkg::*;

   localparam int RandomItems   = 286;
   localparam int IdleMax       = 17;
   localparam int LongHold      = 150;
   localparam int HoldAfter     = 50;
   localparam int WatchdogLimit = 2000;
   localparam int DrainCycles   = 20;

   logic     clock     = 1'b0;
   logic     reset     = 1'b1;
   logic     req_valid = 1'b0;
   logic     req_stall;
   byte_type req_byte  = '0;
   logic     req_last  = 1'b0;
   logic     rsp_valid;
   logic     rsp_stall = 1'b0;
   byte_type rsp_byte;
   logic     rsp_last;

   int errors;
   int outstanding;
   int sent_count   = 0;
   int quiet_cycles = 0;
   int directed_count;
   bit send_eager   = 1'b0;
   bit recv_eager   = 1'b0;
   bit held_long    = 1'b0;

   always #1 clock = ~clock;

   underscore_hex_escape_decoder dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_byte  (req_byte),
      .req_last  (req_last),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_byte  (rsp_byte),
      .rsp_last  (rsp_last)
   );

   uhd_decode_check decode_check (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_byte    (req_byte),
      .req_last    (req_last),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_byte    (rsp_byte),
      .rsp_last    (rsp_last),
      .errors      (errors),
      .outstanding (outstanding)
   );

   task automatic send_byte(input byte_type b, input logic eos);
      int unsigned gap;
      if ($urandom_range(0, 15) == 0) send_eager = !send_eager;
      gap = send_eager ? 0 : $urandom_range(0, IdleMax);
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_byte  <= b;
      req_last  <= eos;
      do @(posedge clock); while (req_stall);
      sent_count++;
   endtask

   task automatic send_string(input string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
   endtask

   function automatic byte_type rand_hex_char();
      int unsigned v;
      v = $urandom_range(0, 15);
      return (v < 10) ? byte_type'(CharZero + v) : byte_type'(CharUpperA + (v - 10));
   endfunction

   task automatic send_random_string();
      byte_type word_q[$];
      int unsigned tokens;
      tokens = $urandom_range(1, 6);
      repeat (tokens) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
               word_q.push_back(CharUnderscore);
               word_q.push_back(rand_hex_char());
               word_q.push_back(rand_hex_char());
            end
            5: begin
               word_q.push_back(CharUnderscore);
               word_q.push_back(rand_hex_char());
               word_q.push_back(byte_type'($urandom_range(0, 255)));
            end
            6: begin
               word_q.push_back(CharUnderscore);
               word_q.push_back(byte_type'($urandom_range(0, 255)));
            end
            7: word_q.push_back(CharUnderscore);
            default: word_q.push_back(byte_type'($urandom_range(0, 255)));
         endcase
      end
      for (int i = 0; i < word_q.size(); i++) send_byte(word_q[i], i == word_q.size() - 1);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_string("_41");
      send_string("_FF");
      send_string("_00");
      send_string("_4a");
      send_string("__41");
      send_string("_4z");
      send_string("_4");
      send_string("_");
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b1);
      directed_count = sent_count;

      while (sent_count < directed_count + RandomItems) send_random_string();
      @(negedge clock);
      req_valid <= 1'b0;

      while (outstanding != 0) @(negedge clock);
      repeat (DrainCycles) @(negedge clock);
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      int unsigned n;
      forever begin
         if (!held_long && sent_count >= HoldAfter) begin
            held_long = 1'b1;
            @(negedge clock);
            rsp_stall <= 1'b1;
            repeat (LongHold) @(negedge clock);
         end
         if ($urandom_range(0, 15) == 0) recv_eager = !recv_eager;
         n = recv_eager ? 0 : $urandom_range(0, IdleMax);
         if (n > 0) begin
            @(negedge clock);
            rsp_stall <= 1'b1;
            repeat (n - 1) @(negedge clock);
         end
         @(negedge clock);
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WatchdogLimit) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule
